>>> hdl/nws3_pkg.sv
// ----------------------------------------------------------------------------
// nws3_pkg
// Shared constants and types for the 3x3 neighbour-weighted stencil.
// ----------------------------------------------------------------------------
package nws3_pkg;

    // configuration register
    localparam int                SIZE_W   = 6;
    localparam logic [SIZE_W-1:0] SIZE_RST = 6'd32;

    // result queue: power of two depth
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // what one item produces as it moves down the pipe
    typedef struct packed {
        logic first;      // result for (r-1, c-1)
        logic second;     // result for (r-1, c) at the last column
        logic frame_end;  // second result closes the frame
        logic run_end;    // last result of this item's run
    } t_emit;

endpackage

>>> hdl/nws3_if.sv
// ----------------------------------------------------------------------------
// nws3 channel interfaces
// Valid/ready channels for config, pixel input and result output.
// ----------------------------------------------------------------------------
interface nws3_cfg_if
    import nws3_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] size_in_use;

    modport source (output valid, output size_in_use, input ready);
    modport sink   (input valid, input size_in_use, output ready);
endinterface

interface nws3_pix_if #(
    parameter int PIXEL_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface nws3_res_if #(
    parameter int SUM_BITS = 21
) ();
    logic                       valid;
    logic                       ready;
    logic signed [SUM_BITS-1:0] weighted_sum;
    logic                       frame_end;
    logic                       run_end;

    modport source (output valid, output weighted_sum, output frame_end,
                    output run_end, input ready);
    modport sink   (input valid, input weighted_sum, input frame_end,
                    input run_end, output ready);
endinterface

>>> hdl/nws3_line_mem.sv
// ----------------------------------------------------------------------------
// nws3_line_mem
// Line store: one port write, one port read, registered read data,
// with forwarding of a write that hits the address being read.
// ----------------------------------------------------------------------------
module nws3_line_mem #(
    parameter int DEPTH = 32,
    parameter int W     = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [W-1:0]             o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [W-1:0]             i_wr_data
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_q;
    logic [W-1:0] r_fwd;
    logic         r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q   <= r_mem[i_rd_addr];
            r_fwd <= i_wr_data;
        end
    end

    // same-cycle write to the entry being read: old data would come out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_fwd : r_q;

endmodule

>>> hdl/nws3_res_fifo.sv
// ----------------------------------------------------------------------------
// nws3_res_fifo
// Small result queue, up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module nws3_res_fifo
    import nws3_pkg::*;
#(
    parameter int W = 23
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_a,
    input  logic [W-1:0] i_data_a,
    input  logic         i_push_b,
    input  logic [W-1:0] i_data_b,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0]       r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_head;
    logic [FIFO_AW-1:0] r_tail;
    logic [FIFO_CW-1:0] r_count;
    logic [FIFO_AW-1:0] w_tail_b;
    logic               w_pop;
    logic [FIFO_CW-1:0] n_count;
    logic [FIFO_AW-1:0] n_tail;

    assign w_tail_b = r_tail + FIFO_AW'(1);
    assign w_pop    = o_valid && i_ready;
    assign n_count  = r_count + FIFO_CW'(i_push_a) + FIFO_CW'(i_push_b) - FIFO_CW'(w_pop);
    assign n_tail   = r_tail + FIFO_AW'(i_push_a) + FIFO_AW'(i_push_b);

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_tail] <= i_data_a;
        end
        if (i_push_b) begin
            r_mem[w_tail_b] <= i_data_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= n_tail;
            r_count <= n_count;
            if (w_pop) begin
                r_head <= r_head + FIFO_AW'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];

endmodule

>>> hdl/neighbour_weighted_stencil_3x3_top.sv
// ----------------------------------------------------------------------------
// neighbour_weighted_stencil_3x3_top
// Zero-padded 3x3 neighbour stencil (corner weight 2, edge weight 3, centre
// unused) over an N x N raster image, results in raster order.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock, unless throttled or flushing, and
// returns, for each position, 2*(corner neighbours) + 3*(edge neighbours),
// i.e. 20x the 0.1/0.15 weighted sum, exact and unsaturated. Results trail
// their inputs by one row: pixel (r, c) releases the result for (r-1, c-1),
// and the last pixel of a row also releases (r-1, N-1). After the last
// pixel of the frame the block sweeps the stored rows to flush the bottom
// row; no pixel is taken during that sweep. The first result of an item
// passes through stage 1, the window, stage 2 and the result queue before
// it is offered. Writing size_in_use (0 reads as 1, values above MAX_SIZE
// clamp) restarts the frame at the top-left corner; write it only while
// the block is idle. The two previous rows live in one single-port-write
// memory of MAX_SIZE entries, each entry holding a column of both rows;
// every item reads its column and writes it back in the following cycle.
// A small queue at the output absorbs the two-results-in-one-cycle case at
// the right edge and decouples output stalls; input is throttled by a
// credit count so that queue never overflows.
// ----------------------------------------------------------------------------
module neighbour_weighted_stencil_3x3_top
    import nws3_pkg::*;
#(
    parameter int MAX_SIZE   = 32,
    parameter int PIXEL_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nws3_cfg_if.sink   i_cfg,
    nws3_pix_if.sink   i_pix,
    nws3_res_if.source o_res
);
    localparam int P        = PIXEL_BITS;
    localparam int SUM_BITS = PIXEL_BITS + 5;
    localparam int CW       = $clog2(MAX_SIZE + 1);  // row runs 0..N (N = flush row)
    localparam int AW       = $clog2(MAX_SIZE);
    localparam int MW       = 2 * PIXEL_BITS;
    localparam int RW       = SUM_BITS + 2;

    function automatic logic [CW-1:0] f_eff(input logic [SIZE_W-1:0] sz);
        logic [CW-1:0] res;
        if (sz == '0) begin
            res = CW'(1);
        end else if (sz > SIZE_W'(MAX_SIZE)) begin
            res = CW'(MAX_SIZE);
        end else begin
            res = CW'(sz);
        end
        return res;
    endfunction

    // ---------------- position and credit ----------------
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [FIFO_CW-1:0] r_resv;   // results queued or still in the pipe
    logic [FIFO_CW-1:0] n_resv;

    logic          w_virt;        // flush row: pixels are implied zeros
    logic          w_c_last;
    logic          w_e1;
    logic          w_e2;
    logic [1:0]    w_cnt;
    logic          w_room;
    logic          w_issue;
    logic          w_last_real;
    logic          w_run;
    logic          w_cfg_wr;
    logic          w_pop;
    logic [CW-1:0] w_n_m1;

    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;
    assign w_n_m1      = r_n - CW'(1);
    assign w_virt      = (r_row == r_n);
    assign w_c_last    = (r_col == w_n_m1);
    assign w_e1        = (r_row != '0) && (r_col != '0);
    assign w_e2        = (r_row != '0) && w_c_last;
    assign w_cnt       = {1'b0, w_e1} + {1'b0, w_e2};
    assign w_room      = (r_resv + FIFO_CW'(w_cnt)) <= FIFO_CW'(FIFO_DEPTH);
    assign w_issue     = w_room && (w_virt || i_pix.valid);
    assign w_last_real = (r_row == w_n_m1) && w_c_last;
    // the last real pixel's run continues through the flush
    assign w_run       = w_virt ? w_c_last : !w_last_real;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !w_virt && w_room;

    assign n_resv = r_resv + (w_issue ? FIFO_CW'(w_cnt) : FIFO_CW'(0)) - FIFO_CW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= f_eff(SIZE_RST);
            r_row  <= '0;
            r_col  <= '0;
            r_resv <= '0;
        end else begin
            r_resv <= n_resv;
            if (w_cfg_wr) begin
                r_n   <= f_eff(i_cfg.size_in_use);
                r_row <= '0;
                r_col <= '0;
            end else if (w_issue) begin
                if (w_c_last) begin
                    r_col <= '0;
                    r_row <= w_virt ? '0 : r_row + CW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // ---------------- stage 1: line store read-modify-write ----------------
    logic                 r_s1_vld;
    logic [CW-1:0]        r_s1_row;
    logic [CW-1:0]        r_s1_col;
    logic signed [P-1:0]  r_s1_pix;
    t_emit                r_s1_emit;
    logic [MW-1:0]        w_rd;
    logic signed [P-1:0]  w_top;
    logic signed [P-1:0]  w_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_row            <= r_row;
            r_s1_col            <= r_col;
            r_s1_pix            <= w_virt ? '0 : i_pix.pixel;
            r_s1_emit.first     <= w_e1;
            r_s1_emit.second    <= w_e2;
            r_s1_emit.frame_end <= w_virt && w_c_last;
            r_s1_emit.run_end   <= w_run;
        end
    end

    nws3_line_mem #(
        .DEPTH (MAX_SIZE),
        .W     (MW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_col[AW-1:0]),
        .o_rd_data (w_rd),
        .i_wr_en   (r_s1_vld),
        .i_wr_addr (r_s1_col[AW-1:0]),
        .i_wr_data ({w_mid, r_s1_pix})
    );

    // rows above the image read as zero
    assign w_top = (r_s1_row >= CW'(2)) ? $signed(w_rd[MW-1:P]) : '0;
    assign w_mid = (r_s1_row != '0)     ? $signed(w_rd[P-1:0])  : '0;

    // ---------------- window: three columns of three rows ----------------
    logic signed [P-1:0] r_win [3][3];   // [row][col], col 2 newest
    logic                r_s2_vld;
    logic                r_s2_lt2;
    logic                r_s2_eq0;
    t_emit               r_s2_emit;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= w_top;
            r_win[1][2] <= w_mid;
            r_win[2][2] <= r_s1_pix;
            r_s2_lt2    <= (r_s1_col < CW'(2));
            r_s2_eq0    <= (r_s1_col == '0);
            r_s2_emit   <= r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    // ---------------- stage 2: corner / edge partial sums ----------------
    logic signed [P-1:0] w_a [3];   // column c-2, zero left of the image
    logic signed [P-1:0] w_b [3];   // column c-1
    logic signed [P-1:0] w_c [3];   // column c
    logic signed [P+1:0] r_s3_k1;
    logic signed [P+1:0] r_s3_g1;
    logic signed [P+1:0] r_s3_k2;
    logic signed [P+1:0] r_s3_g2;
    logic                r_s3_vld;
    t_emit               r_s3_emit;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i] = r_s2_lt2 ? '0 : r_win[i][0];
            w_b[i] = r_s2_eq0 ? '0 : r_win[i][1];
            w_c[i] = r_win[i][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            // centred on column c-1
            r_s3_k1   <= (P+2)'(w_a[0]) + (P+2)'(w_a[2]) + (P+2)'(w_c[0]) + (P+2)'(w_c[2]);
            r_s3_g1   <= (P+2)'(w_b[0]) + (P+2)'(w_a[1]) + (P+2)'(w_c[1]) + (P+2)'(w_b[2]);
            // centred on column c, right neighbours outside
            r_s3_k2   <= (P+2)'(w_b[0]) + (P+2)'(w_b[2]);
            r_s3_g2   <= (P+2)'(w_c[0]) + (P+2)'(w_b[1]) + (P+2)'(w_c[2]);
            r_s3_emit <= r_s2_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    // ---------------- stage 3: weighting and queue push ----------------
    logic signed [SUM_BITS-1:0] w_res1;
    logic signed [SUM_BITS-1:0] w_res2;
    logic                       w_push_a;
    logic                       w_push_b;
    logic [RW-1:0]              w_data_a;
    logic [RW-1:0]              w_data_b;
    logic [RW-1:0]              w_fifo_data;

    assign w_res1 = (SUM_BITS'(r_s3_k1) <<< 1) + SUM_BITS'(r_s3_g1) + (SUM_BITS'(r_s3_g1) <<< 1);
    assign w_res2 = (SUM_BITS'(r_s3_k2) <<< 1) + SUM_BITS'(r_s3_g2) + (SUM_BITS'(r_s3_g2) <<< 1);

    assign w_push_a = r_s3_vld && (r_s3_emit.first || r_s3_emit.second);
    assign w_push_b = r_s3_vld && r_s3_emit.first && r_s3_emit.second;
    assign w_data_b = {w_res2, r_s3_emit.frame_end, r_s3_emit.run_end};
    assign w_data_a = r_s3_emit.first
                    ? {w_res1, 1'b0, r_s3_emit.run_end && !r_s3_emit.second}
                    : w_data_b;

    nws3_res_fifo #(
        .W (RW)
    ) u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (w_push_a),
        .i_data_a (w_data_a),
        .i_push_b (w_push_b),
        .i_data_b (w_data_b),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_data   (w_fifo_data)
    );

    assign w_pop = o_res.valid && o_res.ready;
    assign o_res.weighted_sum = $signed(w_fifo_data[RW-1:2]);
    assign o_res.frame_end    = w_fifo_data[1];
    assign o_res.run_end      = w_fifo_data[0];

    // ---------------- checks ----------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_resv <= FIFO_CW'(FIFO_DEPTH))
        else $error("result credit above queue depth");

    a_frame_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.frame_end |-> o_res.run_end)
        else $error("frame end not on the last result of its run");

    a_flush_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue && w_virt && w_c_last |=> (r_row == '0) && (r_col == '0))
        else $error("position did not wrap after flush");

endmodule

>>> sim/neighbour_weighted_stencil_3x3_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_weighted_stencil_3x3_top_test
// Self-checking bench for the zero-padded 3x3 neighbour stencil. Pixels go
// in over the valid/ready input channel. A behavioral copy of the stencil
// (line store, 3x3 window, raster position) predicts every result at the
// moment its pixel is accepted. Results are matched in order against that
// prediction. Image size is changed only between drained phases.
// ----------------------------------------------------------------------------
module neighbour_weighted_stencil_3x3_top_test;
    import nws3_pkg::*;

    localparam int MAX_SIZE   = 32;
    localparam int PIXEL_BITS = 16;
    localparam int SUM_BITS   = 21;

    localparam logic signed [PIXEL_BITS-1:0] PIX_MAX  = 16'sh7FFF;
    localparam logic signed [PIXEL_BITS-1:0] PIX_MIN  = 16'sh8000;
    localparam logic signed [PIXEL_BITS-1:0] PIX_ZERO = 16'sh0000;
    localparam logic signed [PIXEL_BITS-1:0] PIX_ONES = 16'shFFFF;

    localparam int SETTLE_CYCLES = 12;        // pipe latency plus margin
    localparam int LONG_HOLD     = 400;       // one long output stall
    localparam int RANDOM_ITEMS  = 100;       // before the calm tail phase
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef struct {
        logic signed [SUM_BITS-1:0] sum;
        logic                       frame_end;
        logic                       run_end;
    } t_stencil_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nws3_cfg_if                           cfg_ch ();
    nws3_pix_if #(.PIXEL_BITS(PIXEL_BITS)) pix_ch ();
    nws3_res_if #(.SUM_BITS(SUM_BITS))     res_ch ();

    neighbour_weighted_stencil_3x3_top #(
        .MAX_SIZE   (MAX_SIZE),
        .PIXEL_BITS (PIXEL_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    logic signed [PIXEL_BITS-1:0] pixel_backlog[$];  // pixels not yet offered
    t_stencil_result              due_results[$];    // predicted, not yet seen

    bit idle_on      = 1'b0;  // random gaps on both channels
    bit hold_request = 1'b0;  // asks the hold process for its one long stall
    bit hold_taken   = 1'b0;
    int hold_left    = 0;
    int send_gap     = 0;
    int rcv_gap      = 0;

    int mismatch_count  = 0;
    int results_checked = 0;
    int pixels_accepted = 0;
    int random_items    = 0;
    int size_writes     = 0;

    // ------------------------------------------------------------------------
    // Predictor state: mirrors the block after reset
    // ------------------------------------------------------------------------
    int              line_mem [2*MAX_SIZE];  // [0..] two rows up, [MAX..] one up
    int              win      [3][3];        // rows top..bottom, cols old..new
    int unsigned     row_at = 0;
    int unsigned     col_at = 0;
    logic [SIZE_W-1:0] size_reg = SIZE_RST;

    initial begin
        foreach (line_mem[i]) line_mem[i] = 0;
        foreach (win[i, k]) win[i][k] = 0;
    end

    function automatic int weigh(input int nb [3][3]);
        return 2 * (nb[0][0] + nb[0][2] + nb[2][0] + nb[2][2])
             + 3 * (nb[0][1] + nb[1][0] + nb[1][2] + nb[2][1]);
    endfunction

    // Advances the stencil by one pixel and queues the results it releases,
    // run_end on the last of them.
    function automatic void stencil_predict(input logic signed [PIXEL_BITS-1:0] px);
        int unsigned     n;
        int unsigned     r;
        int unsigned     c;
        int              p;
        int              top;
        int              mid;
        int              col;
        bit              in_img;
        int              nb [3][3];
        int              sums[$];
        bit              ends[$];
        t_stencil_result res;

        n = (size_reg == 0) ? 1 : (size_reg > MAX_SIZE) ? MAX_SIZE : size_reg;
        r = row_at;
        c = col_at;
        if (r >= n || c >= n) begin
            r = 0;
            c = 0;
        end
        p   = int'(px);
        top = (r >= 2) ? line_mem[c] : 0;
        mid = (r >= 1) ? line_mem[MAX_SIZE + c] : 0;
        line_mem[c]            = mid;
        line_mem[MAX_SIZE + c] = p;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = p;

        // interior release: (r-1, c-1); left column padded at c = 1
        if (r >= 1 && c >= 1) begin
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++)
                    nb[i][k] = (k == 0 && c < 2) ? 0 : win[i][k];
            sums.push_back(weigh(nb));
            ends.push_back(1'b0);
        end
        // right edge: (r-1, N-1) with the right column padded
        if (r >= 1 && c == n - 1) begin
            for (int i = 0; i < 3; i++) begin
                nb[i][0] = win[i][1];
                nb[i][1] = win[i][2];
                nb[i][2] = 0;
            end
            sums.push_back(weigh(nb));
            ends.push_back(1'b0);
        end
        // last pixel of the frame flushes the bottom row
        if (r == n - 1 && c == n - 1) begin
            for (int j = 0; j < int'(n); j++) begin
                for (int k = 0; k < 3; k++) begin
                    col    = j + k - 1;
                    in_img = (col >= 0) && (col < int'(n));
                    nb[0][k] = (in_img && n >= 2) ? line_mem[col] : 0;
                    nb[1][k] = in_img ? line_mem[MAX_SIZE + col] : 0;
                    nb[2][k] = 0;
                end
                sums.push_back(weigh(nb));
                ends.push_back(j == int'(n) - 1);
            end
        end
        foreach (sums[i]) begin
            res.sum       = sums[i][SUM_BITS-1:0];
            res.frame_end = ends[i];
            res.run_end   = (i == sums.size() - 1);
            due_results.push_back(res);
        end

        c++;
        if (c >= n) begin
            c = 0;
            r++;
            if (r >= n) r = 0;
        end
        row_at = r;
        col_at = c;
    endfunction

    // ------------------------------------------------------------------------
    // Pixel driver: offers the backlog, holds valid until taken, random gaps
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else if (!pix_ch.valid || pix_ch.ready) begin
            if (send_gap > 0) begin
                send_gap     <= send_gap - 1;
                pix_ch.valid <= 1'b0;
            end else if (pixel_backlog.size() > 0) begin
                pix_ch.valid <= 1'b1;
                pix_ch.pixel <= pixel_backlog.pop_front();
                if (idle_on && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(1, 12);
                end
            end else begin
                pix_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long output stall, counted here so the sender keeps pushing meanwhile
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request && !hold_taken) begin
            hold_left  <= LONG_HOLD;
            hold_taken <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: size writes and pixels update the predictor at acceptance;
    // each accepted result is checked against the oldest prediction.
    // Also drives ready on the result side.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            rcv_gap      <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                // a size write restarts the frame at the top-left corner
                size_reg = cfg_ch.size_in_use;
                row_at   = 0;
                col_at   = 0;
            end
            if (pix_ch.valid && pix_ch.ready) begin
                stencil_predict(pix_ch.pixel);
                pixels_accepted++;
            end
            if (res_ch.valid && res_ch.ready) begin
                if (due_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected result: sum=%0d frame_end=%0b run_end=%0b",
                                 $realtime, res_ch.weighted_sum, res_ch.frame_end,
                                 res_ch.run_end);
                end else begin
                    t_stencil_result want;
                    want = due_results.pop_front();
                    results_checked++;
                    if (want.sum !== res_ch.weighted_sum ||
                        want.frame_end !== res_ch.frame_end ||
                        want.run_end !== res_ch.run_end) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("[%0t] result %0d mismatch: expected sum=%0d fe=%0b re=%0b",
                                     $realtime, results_checked, want.sum,
                                     want.frame_end, want.run_end);
                            $display("    got sum=%0d fe=%0b re=%0b",
                                     res_ch.weighted_sum, res_ch.frame_end,
                                     res_ch.run_end);
                        end
                    end
                end
            end
            if (rcv_gap > 0) begin
                rcv_gap      <= rcv_gap - 1;
                res_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                rcv_gap      <= $urandom_range(0, 11);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= (hold_left == 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [PIXEL_BITS-1:0] pick_pixel();
        logic [31:0] roll;
        int          near_zero;
        roll      = $urandom();
        near_zero = int'($urandom_range(0, 200)) - 100;
        case ($urandom_range(0, 9))
            0:       return PIX_MAX;
            1:       return PIX_MIN;
            2:       return roll[0] ? PIX_ZERO : PIX_ONES;
            3, 4:    return near_zero[PIXEL_BITS-1:0];
            default: return roll[PIXEL_BITS-1:0];
        endcase
    endfunction

    task automatic feed_random(input int count);
        for (int i = 0; i < count; i++) pixel_backlog.push_back(pick_pixel());
        random_items += count;
    endtask

    // Waits until the backlog is offered and every predicted result is back,
    // then lets the pipe settle since trailing pixels may release nothing.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pixel_backlog.size() != 0 || pix_ch.valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] side);
        @(posedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.size_in_use <= side;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        size_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned side;
        int unsigned n;
        int          count;

        i_rst_n            = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.size_in_use = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel       = '0;
        res_ch.ready       = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        // Reset size (32): two pixels of row 0 release nothing, then the
        // size write below abandons the frame mid-row.
        pixel_backlog.push_back(PIX_MAX);
        pixel_backlog.push_back(PIX_MIN);
        wait_idle();

        // Size zero acts as a 1x1 image: one pixel, one result of 0.
        write_size(6'd0);
        pixel_backlog.push_back(PIX_MAX);
        wait_idle();

        // 2x2 image: results from the interior, edge and flush rules.
        write_size(6'd2);
        pixel_backlog.push_back(PIX_MIN);
        pixel_backlog.push_back(PIX_MAX);
        pixel_backlog.push_back(PIX_MAX);
        pixel_backlog.push_back(PIX_MIN);
        wait_idle();

        // 3x3 all max then all min: centre hits both extremes of the sum.
        write_size(6'd3);
        repeat (9) pixel_backlog.push_back(PIX_MAX);
        repeat (9) pixel_backlog.push_back(PIX_MIN);
        wait_idle();

        // Oversized write clamps to 32. Output stalls for a long stretch
        // while the sender keeps going, so the result queue fills and the
        // input must back off.
        write_size(6'd63);
        hold_request = 1'b1;
        feed_random(50);
        wait_idle();

        // Full size; sender pauses mid-frame until everything has drained.
        idle_on = 1'b1;
        write_size(6'd32);
        feed_random(20);
        wait_idle();
        feed_random(20);
        wait_idle();

        // Random phases, mostly small images, whole frames back to back
        // and sometimes a partial frame cut short by the next size write.
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       side = 0;
                1:       side = $urandom_range(7, 10);
                default: side = $urandom_range(1, 6);
            endcase
            n     = (side == 0) ? 1 : side;
            count = (n > 6) ? n * n : n * n * $urandom_range(1, 2);
            if (n > 1 && $urandom_range(0, 3) == 0) count += $urandom_range(1, n * n - 1);
            idle_on = ($urandom_range(0, 3) != 0);
            write_size(side[SIZE_W-1:0]);
            feed_random(count);
            wait_idle();
        end

        // Tail: no idling on either side.
        idle_on = 1'b0;
        write_size(6'd5);
        feed_random(25);
        wait_idle();
        repeat (20) @(posedge i_clk);

        if (due_results.size() != 0) begin
            $display("%0d predicted results never arrived", due_results.size());
            mismatch_count += due_results.size();
        end

        $display("Covered %0d pixels across %0d size writes (sizes 0..63, clamped),",
                 pixels_accepted, size_writes);
        $display("%0d results checked", results_checked);
        $display("Included a %0d-cycle output stall, mid-frame drains and burst idling; %0d errors",
                 LONG_HOLD, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still due", due_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
hdl/nws3_pkg.sv
hdl/nws3_if.sv
hdl/nws3_line_mem.sv
hdl/nws3_res_fifo.sv
hdl/neighbour_weighted_stencil_3x3_top.sv
sim/neighbour_weighted_stencil_3x3_top_test.sv
